/* rtl/core/complex_integer_alu_macros.svh */
// assertion macros for the complex integer alu checker
// no dependencies; included by the checker file
`ifndef COMPLEX_INTEGER_ALU_MACROS_SVH
`define COMPLEX_INTEGER_ALU_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define CIA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent checked in the cycle after the antecedent
`define CIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/cia_pkg.sv */
// shared types and constants of the complex integer alu
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package cia_pkg;

  localparam int unsigned OpW  = 16;
  localparam int unsigned ResW = 33;
  localparam int unsigned QW   = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // payload travelling down the divider stages
  typedef struct packed {
    logic                   is_div;
    logic                   dz;
    logic                   neg_re;
    logic                   neg_im;
    logic [QW-1:0]          rem_re;
    logic [QW-1:0]          rem_im;
    logic [QW-1:0]          dq_re;
    logic [QW-1:0]          dq_im;
    logic [QW-1:0]          den;
    logic signed [ResW-1:0] pass_re;
    logic signed [ResW-1:0] pass_im;
  } div_lane_t;

endpackage
`default_nettype wire

/* rtl/core/cia_if.sv */
// valid/ready channel interfaces of the complex integer alu
// depends on cia_pkg
`timescale 1ns / 1ps
`default_nettype none
interface cia_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       opcode;
  logic signed [cia_pkg::OpW-1:0]   a_re;
  logic signed [cia_pkg::OpW-1:0]   a_im;
  logic signed [cia_pkg::OpW-1:0]   b_re;
  logic signed [cia_pkg::OpW-1:0]   b_im;
  modport source (output valid, opcode, a_re, a_im, b_re, b_im, input ready);
  modport sink (input valid, opcode, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cia_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [cia_pkg::ResW-1:0]  res_re;
  logic signed [cia_pkg::ResW-1:0]  res_im;
  logic                             div_zero;
  modport source (output valid, res_re, res_im, div_zero, input ready);
  modport sink (input valid, res_re, res_im, div_zero, output ready);
endinterface
`default_nettype wire

/* rtl/core/cia_front.sv */
// front end: products and sums in stage one, combination and magnitudes in stage two
// depends on cia_pkg
`timescale 1ns / 1ps
`default_nettype none
module cia_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           valid_i,
  input  wire logic [1:0]                     opcode_i,
  input  wire logic signed [cia_pkg::OpW-1:0] a_re_i,
  input  wire logic signed [cia_pkg::OpW-1:0] a_im_i,
  input  wire logic signed [cia_pkg::OpW-1:0] b_re_i,
  input  wire logic signed [cia_pkg::OpW-1:0] b_im_i,
  output logic                                valid_o,
  output cia_pkg::div_lane_t                  lane_o
);
  import cia_pkg::*;

  logic                   v1_q;
  op_e                    op_q;
  logic signed [OpW:0]    s_re_q, s_im_q;
  logic signed [2*OpW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, p_bbr_q, p_bbi_q;
  logic signed [OpW:0]    s_re_d, s_im_d;

  logic                    v2_q;
  div_lane_t               lane_q, lane_d;
  logic signed [ResW-1:0]  mul_re, mul_im, num_re, num_im, neg_num_re, neg_num_im;
  logic [ResW-1:0]         den_w;

  always_comb begin
    unique case (op_e'(opcode_i))
      OP_SUB: begin
        s_re_d = $signed({a_re_i[OpW-1], a_re_i}) - $signed({b_re_i[OpW-1], b_re_i});
        s_im_d = $signed({a_im_i[OpW-1], a_im_i}) - $signed({b_im_i[OpW-1], b_im_i});
      end
      default: begin
        s_re_d = $signed({a_re_i[OpW-1], a_re_i}) + $signed({b_re_i[OpW-1], b_re_i});
        s_im_d = $signed({a_im_i[OpW-1], a_im_i}) + $signed({b_im_i[OpW-1], b_im_i});
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q    <= op_e'(opcode_i);
      s_re_q  <= s_re_d;
      s_im_q  <= s_im_d;
      p_rr_q  <= a_re_i * b_re_i;
      p_ii_q  <= a_im_i * b_im_i;
      p_ri_q  <= a_re_i * b_im_i;
      p_ir_q  <= a_im_i * b_re_i;
      p_bbr_q <= b_re_i * b_re_i;
      p_bbi_q <= b_im_i * b_im_i;
      lane_q  <= lane_d;
    end
  end

  always_comb begin
    mul_re     = ResW'(p_rr_q) - ResW'(p_ii_q);
    mul_im     = ResW'(p_ri_q) + ResW'(p_ir_q);
    num_re     = ResW'(p_rr_q) + ResW'(p_ii_q);
    num_im     = ResW'(p_ir_q) - ResW'(p_ri_q);
    neg_num_re = -num_re;
    neg_num_im = -num_im;
    // squares are non-negative, sum stays below 2^32
    den_w      = ResW'(p_bbr_q) + ResW'(p_bbi_q);

    lane_d         = '0;
    lane_d.is_div  = (op_q == OP_DIV);
    lane_d.den     = den_w[QW-1:0];
    lane_d.dz      = (op_q == OP_DIV) && (den_w == '0);
    lane_d.neg_re  = num_re[ResW-1];
    lane_d.neg_im  = num_im[ResW-1];
    lane_d.dq_re   = num_re[ResW-1] ? neg_num_re[QW-1:0] : num_re[QW-1:0];
    lane_d.dq_im   = num_im[ResW-1] ? neg_num_im[QW-1:0] : num_im[QW-1:0];
    unique case (op_q)
      OP_MUL: begin
        lane_d.pass_re = mul_re;
        lane_d.pass_im = mul_im;
      end
      OP_DIV: begin
        lane_d.pass_re = '0;
        lane_d.pass_im = '0;
      end
      default: begin
        lane_d.pass_re = ResW'(s_re_q);
        lane_d.pass_im = ResW'(s_im_q);
      end
    endcase
  end

  assign valid_o = v2_q;
  assign lane_o  = lane_q;

endmodule
`default_nettype wire

/* rtl/core/cia_div_step.sv */
// one restoring division step for both quotient lanes, registered
// depends on cia_pkg
`timescale 1ns / 1ps
`default_nettype none
module cia_div_step (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire cia_pkg::div_lane_t lane_i,
  output logic                    valid_o,
  output cia_pkg::div_lane_t      lane_o
);
  import cia_pkg::*;

  logic            valid_q;
  div_lane_t       lane_q, lane_d;
  logic [QW:0]     t_re, t_im, d_re, d_im;

  always_comb begin
    t_re   = {lane_i.rem_re, lane_i.dq_re[QW-1]};
    t_im   = {lane_i.rem_im, lane_i.dq_im[QW-1]};
    d_re   = t_re - {1'b0, lane_i.den};
    d_im   = t_im - {1'b0, lane_i.den};
    lane_d = lane_i;
    // no borrow means the trial subtraction fits
    lane_d.rem_re = d_re[QW] ? t_re[QW-1:0] : d_re[QW-1:0];
    lane_d.rem_im = d_im[QW] ? t_im[QW-1:0] : d_im[QW-1:0];
    lane_d.dq_re  = {lane_i.dq_re[QW-2:0], ~d_re[QW]};
    lane_d.dq_im  = {lane_i.dq_im[QW-2:0], ~d_im[QW]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule
`default_nettype wire

/* rtl/core/complex_integer_alu.sv */
// top level of the complex integer alu: front end, divider chain, output register
// depends on cia_pkg, cia_if, cia_front and cia_div_step
//
// usage
//   in_i carries one operation per transaction: opcode (add, subtract,
//   multiply, divide) and two signed 16-bit complex operands
//   out_o returns one transaction per input: 33-bit real and imaginary
//   parts and div_zero, set when a divide meets a zero divisor (parts zero)
// pipeline and throughput
//   every operation passes from acceptance to out_o valid through two
//   front stages (products, then combination and magnitudes), 32 stages of
//   a bit-per-stage restoring divider that all opcodes pass through, and
//   the output register; one transaction is accepted every unstalled cycle
// reset
//   rst_ni clears every valid bit at once; no item is in flight afterwards
// stall
//   the whole pipeline advances when the output register is empty or
//   taken; while out_o is held, in_i.ready is low and nothing moves
`timescale 1ns / 1ps
`default_nettype none
module complex_integer_alu (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cia_in_if.sink    in_i,
  cia_out_if.source out_o
);
  import cia_pkg::*;

  // global advance for every stage
  logic adv;

  logic      vld [0:QW];
  div_lane_t lane [0:QW];

  logic                   out_valid_q;
  logic signed [ResW-1:0] res_re_q, res_im_q, res_re_d, res_im_d;
  logic                   dz_q;
  logic signed [ResW-1:0] q_re, q_im;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  cia_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (in_i.valid),
    .opcode_i (in_i.opcode),
    .a_re_i   (in_i.a_re),
    .a_im_i   (in_i.a_im),
    .b_re_i   (in_i.b_re),
    .b_im_i   (in_i.b_im),
    .valid_o  (vld[0]),
    .lane_o   (lane[0])
  );

  // one quotient bit per stage, most significant first
  for (genvar g = 0; g < QW; g++) begin : g_div
    cia_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (vld[g]),
      .lane_i  (lane[g]),
      .valid_o (vld[g+1]),
      .lane_o  (lane[g+1])
    );
  end

  // sign restore: quotient truncates toward zero
  always_comb begin
    q_re = lane[QW].neg_re ? -$signed({1'b0, lane[QW].dq_re})
                           :  $signed({1'b0, lane[QW].dq_re});
    q_im = lane[QW].neg_im ? -$signed({1'b0, lane[QW].dq_im})
                           :  $signed({1'b0, lane[QW].dq_im});
    if (!lane[QW].is_div) begin
      res_re_d = lane[QW].pass_re;
      res_im_d = lane[QW].pass_im;
    end else if (lane[QW].dz) begin
      res_re_d = '0;
      res_im_d = '0;
    end else begin
      res_re_d = q_re;
      res_im_d = q_im;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_re_q <= res_re_d;
      res_im_q <= res_im_d;
      dz_q     <= lane[QW].dz;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.res_re   = res_re_q;
  assign out_o.res_im   = res_im_q;
  assign out_o.div_zero = dz_q;

endmodule
`default_nettype wire

/* rtl/core/cia_checker.sv */
// port-level checks of the complex integer alu, bound to the top level
// depends on cia_pkg, complex_integer_alu_macros.svh and complex_integer_alu
`timescale 1ns / 1ps
`default_nettype none
`include "complex_integer_alu_macros.svh"
module cia_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_ready_i,
  input wire logic                           out_valid_i,
  input wire logic                           out_ready_i,
  input wire logic signed [cia_pkg::ResW-1:0] res_re_i,
  input wire logic signed [cia_pkg::ResW-1:0] res_im_i,
  input wire logic                           div_zero_i
);
  import cia_pkg::*;

  // a held result blocks the input side
  `CIA_ASSERT_IMP(a_stall_blocks, clk_i, rst_ni, out_valid_i && !out_ready_i, !in_ready_i)
  // an empty or draining output lets the input through
  `CIA_ASSERT_IMP(a_free_takes, clk_i, rst_ni, !out_valid_i || out_ready_i, in_ready_i)
  // a divide-by-zero transaction carries zero parts
  `CIA_ASSERT_IMP(a_dz_zero, clk_i, rst_ni, out_valid_i && div_zero_i,
                  res_re_i == '0 && res_im_i == '0)
  // a stalled result holds
  `CIA_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(res_re_i) && $stable(res_im_i))

endmodule

bind complex_integer_alu cia_checker u_cia_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .res_re_i    (out_o.res_re),
  .res_im_i    (out_o.res_im),
  .div_zero_i  (out_o.div_zero)
);
`default_nettype wire

/* bench/tb_top.sv */
// self-checking bench for the complex integer alu: directed and random operations
// depends on cia_pkg, cia_if and the complex_integer_alu rtl
`timescale 1ns / 1ps
`default_nettype none

// holds expected results of accepted operations and checks returned ones
class cia_result_book;
  typedef struct {
    logic signed [32:0] re;
    logic signed [32:0] im;
    logic               dz;
  } cplx_res_t;

  cplx_res_t pending[$];
  int        mismatches;

  function void note_operation(cia_pkg::op_e op, logic signed [15:0] ar,
                               logic signed [15:0] ai, logic signed [15:0] br,
                               logic signed [15:0] bi);
    cplx_res_t r;
    longint    xr, xi, yr, yi, den;
    xr = ar; xi = ai; yr = br; yi = bi;
    r.re = '0; r.im = '0; r.dz = 1'b0;
    case (op)
      cia_pkg::OP_ADD: begin
        r.re = 33'(xr + yr); r.im = 33'(xi + yi);
      end
      cia_pkg::OP_SUB: begin
        r.re = 33'(xr - yr); r.im = 33'(xi - yi);
      end
      cia_pkg::OP_MUL: begin
        r.re = 33'(xr * yr - xi * yi); r.im = 33'(xr * yi + xi * yr);
      end
      default: begin
        den = yr * yr + yi * yi;
        if (den == 0) r.dz = 1'b1;
        else begin
          // longint division truncates toward zero
          r.re = 33'((xr * yr + xi * yi) / den);
          r.im = 33'((xi * yr - xr * yi) / den);
        end
      end
    endcase
    pending.push_back(r);
  endfunction

  function void check_result(logic signed [32:0] re, logic signed [32:0] im, logic dz);
    cplx_res_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result re=%0d im=%0d dz=%0b", re, im, dz);
      return;
    end
    e = pending.pop_front();
    if (re !== e.re || im !== e.im || dz !== e.dz) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected re=%0d im=%0d dz=%0b, got re=%0d im=%0d dz=%0b",
                 e.re, e.im, e.dz, re, im, dz);
    end
  endfunction
endclass

module tb_top;
  import cia_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned Latency    = 35;

  logic clk_i;
  logic rst_ni;
  int   cycles;
  bit   calm;          // no idling on either side while set

  cia_in_if  in_ch ();
  cia_out_if out_ch ();

  complex_integer_alu DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  cia_result_book book;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // result side: random back-pressure, check each accepted transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready)
        book.check_result(out_ch.res_re, out_ch.res_im, out_ch.div_zero);
      out_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 24);
    end
  end

  // present one operation and hold it until accepted
  task automatic send_op(op_e op, logic [15:0] ar, logic [15:0] ai,
                         logic [15:0] br, logic [15:0] bi);
    // optional idle gap before the transaction
    while (!calm && $urandom_range(0, 99) < 24) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.a_re   <= ar;
    in_ch.a_im   <= ai;
    in_ch.b_re   <= br;
    in_ch.b_im   <= bi;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    book.note_operation(op, ar, ai, br, bi);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk_i);
  endtask

  // random operand: extremes, small values or anything
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    op_e opk;
    book   = new();
    cycles = 0;
    calm   = 1'b0;
    rst_ni = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.opcode = OP_ADD;
    in_ch.a_re   = '0;
    in_ch.a_im   = '0;
    in_ch.b_re   = '0;
    in_ch.b_im   = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every operation at the field extremes and on small values
    for (int k = 0; k < 4; k++) begin
      opk = op_e'(k);
      send_op(opk, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_op(opk, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_op(opk, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
      send_op(opk, 16'hffff, 16'h0001, 16'h0003, 16'hfffe);
    end
    // division by a zero divisor, and truncation toward zero of negative quotients
    send_op(OP_DIV, 16'h1234, 16'hedcb, 16'h0000, 16'h0000);
    send_op(OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_op(OP_DIV, 16'hfff9, 16'h0007, 16'h0002, 16'h0000);
    send_op(OP_DIV, 16'h0001, 16'h0000, 16'h0000, 16'h8000);
    send_op(OP_DIV, 16'h8000, 16'h8000, 16'h0000, 16'h0001);

    // hold off until the pipeline is empty
    drain();

    // random: one stretch with no idling on either side
    for (int n = 0; n < 1550; n++) begin
      calm = (n >= 600 && n < 800);
      opk  = op_e'($urandom_range(0, 3));
      if (opk == OP_DIV && $urandom_range(0, 19) == 0)
        send_op(opk, pick_operand(), pick_operand(), 16'h0000, 16'h0000);
      else
        send_op(opk, pick_operand(), pick_operand(), pick_operand(), pick_operand());
    end
    calm = 1'b0;

    drain();
    repeat (Latency + 5) @(posedge clk_i);
    if (book.mismatches == 0 && book.pending.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* complex_integer_alu.f */
+incdir+rtl/core
rtl/core/cia_pkg.sv
rtl/core/cia_if.sv
rtl/core/cia_front.sv
rtl/core/cia_div_step.sv
rtl/core/complex_integer_alu.sv
rtl/core/cia_checker.sv
bench/tb_top.sv
